@@ rtl/core/gpbs_pkg.sv @@
// gpbs_pkg: constants, codes and control/status structs of the gravity particle bitmap core
// no dependencies; imported by the controller, datapath and top level, referenced by gpbs_in_if
package gpbs_pkg;

  localparam int GRID_WIDTH  = 128;
  localparam int GRID_HEIGHT = 64;
  localparam int BYTE_W      = 8;
  localparam int PAGE_COUNT  = (GRID_HEIGHT + BYTE_W - 1) / BYTE_W;
  localparam int STORE_BYTES = PAGE_COUNT * GRID_WIDTH;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int BIT_W       = $clog2(BYTE_W);

  localparam int CMD_W = 2;
  localparam int X_W   = 7;
  localparam int Y_W   = 6;
  localparam int G_W   = 16;
  localparam int DZ_W  = 15;

  localparam logic [DZ_W-1:0] DEAD_ZONE_RESET = DZ_W'(2);

  typedef enum logic [CMD_W-1:0] {
    CMD_SPAWN = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ADDR_CLEAR = 2'd0,
    ADDR_CELL  = 2'd1,
    ADDR_SRC   = 2'd2,
    ADDR_TGT   = 2'd3
  } addr_sel_e;

  typedef enum logic [2:0] {
    WR_NONE     = 3'd0,
    WR_ZERO     = 3'd1,
    WR_SPAWN    = 3'd2,
    WR_TGT      = 3'd3,
    WR_TGT_SAME = 3'd4,
    WR_SRC      = 3'd5
  } wr_op_e;

  typedef struct packed {
    logic      clear_step;
    logic      load;
    logic      mem_rd;
    addr_sel_e addr_sel;
    wr_op_e    wr_op;
    logic      capture_read;
    logic      capture_src;
    logic      scan_next;
    logic      res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    cmd_e cmd;
    logic cell_ok;
    logic src_set;
    logic tgt_ok;
    logic tgt_set;
    logic same_addr;
    logic scan_last;
    logic res_free;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [X_W-1:0] x,
                                                  input logic [Y_W-1:0] y);
    return ADDR_W'((int'(y) / BYTE_W) * GRID_WIDTH + int'(x));
  endfunction

  function automatic logic [BYTE_W-1:0] cell_mask(input logic [Y_W-1:0] y);
    return BYTE_W'(1) << y[BIT_W-1:0];
  endfunction

endpackage

@@ rtl/core/gpbs_in_if.sv @@
// gpbs_in_if: command channel, valid/ready plus command payload
// depends on gpbs_pkg for field widths
interface gpbs_in_if;
  logic                               valid;
  logic                               ready;
  logic [gpbs_pkg::CMD_W-1:0]         cmd;
  logic [gpbs_pkg::X_W-1:0]           cell_x;
  logic [gpbs_pkg::Y_W-1:0]           cell_y;
  logic signed [gpbs_pkg::G_W-1:0]    grav_x;
  logic signed [gpbs_pkg::G_W-1:0]    grav_y;

  modport source (output valid, cmd, cell_x, cell_y, grav_x, grav_y, input ready);
  modport sink   (input valid, cmd, cell_x, cell_y, grav_x, grav_y, output ready);
endinterface

@@ rtl/core/gpbs_out_if.sv @@
// gpbs_out_if: result channel, valid/ready plus cell value and done flag
// no dependencies
interface gpbs_out_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic done_res;

  modport source (output valid, cell_value, done_res, input ready);
  modport sink   (input valid, cell_value, done_res, output ready);
endinterface

@@ rtl/core/gpbs_ctrl.sv @@
// gpbs_ctrl: sequencer for clearing, spawn, read and the gravity scan
// depends on gpbs_pkg; drives gpbs_datapath through ctrl_cmd_t, reads dp_status_t
module gpbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  gpbs_pkg::dp_status_t status_i,
  output gpbs_pkg::ctrl_cmd_t  cmd_o
);
  import gpbs_pkg::*;

  typedef enum logic [10:0] {
    S_CLEAR    = 11'b000_0000_0001,
    S_IDLE     = 11'b000_0000_0010,
    S_DISPATCH = 11'b000_0000_0100,
    S_SPAWN_WR = 11'b000_0000_1000,
    S_READ_CAP = 11'b000_0001_0000,
    S_SRC_RD   = 11'b000_0010_0000,
    S_SRC_CHK  = 11'b000_0100_0000,
    S_TGT_CHK  = 11'b000_1000_0000,
    S_SRC_WR   = 11'b001_0000_0000,
    S_NEXT     = 11'b010_0000_0000,
    S_FINISH   = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.addr_sel   = ADDR_CLEAR;
        cmd_o.wr_op      = WR_ZERO;
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status_i.cmd)
          CMD_SPAWN: begin
            if (status_i.cell_ok) begin
              cmd_o.mem_rd   = 1'b1;
              cmd_o.addr_sel = ADDR_CELL;
              state_d        = S_SPAWN_WR;
            end else begin
              state_d = S_FINISH;
            end
          end
          CMD_READ: begin
            if (status_i.cell_ok) begin
              cmd_o.mem_rd   = 1'b1;
              cmd_o.addr_sel = ADDR_CELL;
              state_d        = S_READ_CAP;
            end else begin
              state_d = S_FINISH;
            end
          end
          CMD_STEP: state_d = S_SRC_RD;
          CMD_NOP:  state_d = S_FINISH;
          default:  state_d = S_FINISH;
        endcase
      end
      S_SPAWN_WR: begin
        cmd_o.addr_sel = ADDR_CELL;
        cmd_o.wr_op    = WR_SPAWN;
        state_d        = S_FINISH;
      end
      S_READ_CAP: begin
        cmd_o.capture_read = 1'b1;
        state_d            = S_FINISH;
      end
      S_SRC_RD: begin
        cmd_o.mem_rd   = 1'b1;
        cmd_o.addr_sel = ADDR_SRC;
        state_d        = S_SRC_CHK;
      end
      S_SRC_CHK: begin
        cmd_o.capture_src = 1'b1;
        if (status_i.src_set && status_i.tgt_ok) begin
          cmd_o.mem_rd   = 1'b1;
          cmd_o.addr_sel = ADDR_TGT;
          state_d        = S_TGT_CHK;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_TGT_CHK: begin
        cmd_o.addr_sel = ADDR_TGT;
        if (status_i.tgt_set) begin
          state_d = S_NEXT;
        end else if (status_i.same_addr) begin
          cmd_o.wr_op = WR_TGT_SAME;
          state_d     = S_NEXT;
        end else begin
          cmd_o.wr_op = WR_TGT;
          state_d     = S_SRC_WR;
        end
      end
      S_SRC_WR: begin
        cmd_o.addr_sel = ADDR_SRC;
        cmd_o.wr_op    = WR_SRC;
        state_d        = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.scan_next = 1'b1;
        state_d         = status_i.scan_last ? S_FINISH : S_SRC_RD;
      end
      S_FINISH: begin
        if (status_i.res_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/gpbs_datapath.sv @@
// gpbs_datapath: bitmap memory, scan counters, gravity quantizer and result register
// depends on gpbs_pkg; sequenced by gpbs_ctrl
module gpbs_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gpbs_pkg::ctrl_cmd_t            cmd_i,
  output gpbs_pkg::dp_status_t           status_o,
  input  logic [gpbs_pkg::CMD_W-1:0]     in_cmd_i,
  input  logic [gpbs_pkg::X_W-1:0]       in_cell_x_i,
  input  logic [gpbs_pkg::Y_W-1:0]       in_cell_y_i,
  input  logic signed [gpbs_pkg::G_W-1:0] in_grav_x_i,
  input  logic signed [gpbs_pkg::G_W-1:0] in_grav_y_i,
  input  logic                           cfg_we_i,
  input  logic [gpbs_pkg::DZ_W-1:0]      cfg_wdata_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           cell_value_o
);
  import gpbs_pkg::*;

  logic [BYTE_W-1:0] bitmap_q [STORE_BYTES];
  logic [BYTE_W-1:0] rdata_q;
  logic [BYTE_W-1:0] src_byte_q;
  logic [BYTE_W-1:0] wdata;
  logic [ADDR_W-1:0] addr;
  logic              mem_we;

  logic [ADDR_W-1:0] clr_q;
  logic [DZ_W-1:0]   dead_zone_q;
  cmd_e              cmd_q;
  logic [X_W-1:0]    cx_q;
  logic [Y_W-1:0]    cy_q;
  logic              dxn_q, dxp_q, dyn_q, dyp_q;
  logic [X_W-1:0]    sx_q;
  logic [Y_W-1:0]    sy_q;
  logic              res_value_q;
  logic              out_valid_q;
  logic              cell_value_q;

  logic signed [G_W:0] gx, gy, dz_pos, dz_neg;
  logic [X_W-1:0]      tx;
  logic [Y_W-1:0]      ty;
  logic [ADDR_W-1:0]   caddr, saddr, taddr;
  logic [BYTE_W-1:0]   cmask, smask, tmask;
  logic                res_free;

  // dead zone quantizer, sampled at command load
  assign gx     = {in_grav_x_i[G_W-1], in_grav_x_i};
  assign gy     = {in_grav_y_i[G_W-1], in_grav_y_i};
  assign dz_pos = $signed({2'b00, dead_zone_q});
  assign dz_neg = -dz_pos;

  always_comb begin
    tx = sx_q;
    if (dxp_q) begin
      tx = sx_q + X_W'(1);
    end else if (dxn_q) begin
      tx = sx_q - X_W'(1);
    end
    ty = sy_q;
    if (dyp_q) begin
      ty = sy_q + Y_W'(1);
    end else if (dyn_q) begin
      ty = sy_q - Y_W'(1);
    end
  end

  assign caddr = cell_addr(cx_q, cy_q);
  assign saddr = cell_addr(sx_q, sy_q);
  assign taddr = cell_addr(tx, ty);
  assign cmask = cell_mask(cy_q);
  assign smask = cell_mask(sy_q);
  assign tmask = cell_mask(ty);

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_CLEAR: addr = clr_q;
      ADDR_CELL:  addr = caddr;
      ADDR_SRC:   addr = saddr;
      ADDR_TGT:   addr = taddr;
      default:    addr = clr_q;
    endcase
  end

  always_comb begin
    mem_we = 1'b1;
    unique case (cmd_i.wr_op)
      WR_ZERO:     wdata = '0;
      WR_SPAWN:    wdata = rdata_q | cmask;
      WR_TGT:      wdata = rdata_q | tmask;
      WR_TGT_SAME: wdata = (rdata_q | tmask) & ~smask;
      WR_SRC:      wdata = src_byte_q & ~smask;
      default: begin
        mem_we = 1'b0;
        wdata  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bitmap_q[addr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= bitmap_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_e'(in_cmd_i);
      cx_q  <= in_cell_x_i;
      cy_q  <= in_cell_y_i;
      dxn_q <= gx < dz_neg;
      dxp_q <= gx > dz_pos;
      dyn_q <= gy < dz_neg;
      dyp_q <= gy > dz_pos;
    end
    if (cmd_i.capture_src) begin
      src_byte_q <= rdata_q;
    end
    if (cmd_i.res_load) begin
      cell_value_q <= res_value_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      dead_zone_q <= DEAD_ZONE_RESET;
      sx_q        <= '0;
      sy_q        <= Y_W'(GRID_HEIGHT - 2);
      res_value_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (cfg_we_i) begin
        dead_zone_q <= cfg_wdata_i;
      end
      if (cmd_i.load) begin
        sx_q        <= '0;
        sy_q        <= Y_W'(GRID_HEIGHT - 2);
        res_value_q <= 1'b0;
      end else if (cmd_i.scan_next) begin
        if (sx_q == X_W'(GRID_WIDTH - 1)) begin
          sx_q <= '0;
          sy_q <= sy_q - Y_W'(1);
        end else begin
          sx_q <= sx_q + X_W'(1);
        end
      end
      if (cmd_i.capture_read) begin
        res_value_q <= |(rdata_q & cmask);
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o            = '0;
    status_o.clear_last = (clr_q == ADDR_W'(STORE_BYTES - 1));
    status_o.cmd        = cmd_q;
    status_o.cell_ok    = (int'(cx_q) < GRID_WIDTH) && (int'(cy_q) < GRID_HEIGHT);
    status_o.src_set    = |(rdata_q & smask);
    status_o.tgt_ok     = !(dxn_q && sx_q == '0) &&
                          !(dxp_q && sx_q == X_W'(GRID_WIDTH - 1)) &&
                          !(dyn_q && sy_q == '0) &&
                          !(dyp_q && sy_q == Y_W'(GRID_HEIGHT - 1));
    status_o.tgt_set    = |(rdata_q & tmask);
    status_o.same_addr  = (taddr == saddr);
    status_o.scan_last  = (sx_q == X_W'(GRID_WIDTH - 1)) && (sy_q == Y_W'(1));
    status_o.res_free   = res_free;
  end

  assign out_valid_o  = out_valid_q;
  assign cell_value_o = cell_value_q;

  a_no_rd_wr_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.mem_rd && mem_we))
    else $error("bitmap read and write issued in the same cycle");

  a_res_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  a_res_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.res_load |=> out_valid_q)
    else $error("loaded result not presented");

  a_scan_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.addr_sel == ADDR_SRC) |-> (sy_q >= Y_W'(1) && sy_q <= Y_W'(GRID_HEIGHT - 2)))
    else $error("scan row out of interior range");

endmodule

@@ rtl/core/gravity_particle_bitmap_step_core.sv @@
// After reset the core clears all STORE_BYTES (1024) bytes of the bitmap memory and
// accepts no beat meanwhile; dead zone writes are taken at any time. The bitmap sits in a
// single-port memory with registered read data, so each command runs as a sequence of
// memory accesses: spawn reads the cell's byte and writes it back with the bit set, read
// reads the byte and captures the bit, and the next command can be taken in the cycle
// after the result is loaded. A step visits the (GRID_HEIGHT-2)*GRID_WIDTH interior
// cells (7936) one after another, reading and checking each source byte; an occupied
// cell with an on-grid target reads the target byte and sets the bit if it is free, and
// a move to another byte also clears the source bit. One command is worked at a time;
// a finished result waits in an output register while the next command is accepted.
// top level: depends on gpbs_pkg, gpbs_in_if, gpbs_out_if, gpbs_ctrl and gpbs_datapath
module gravity_particle_bitmap_step_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gpbs_in_if.sink                   req_i,
  gpbs_out_if.source                rsp_o,
  input  logic                      cfg_we_i,
  input  logic [gpbs_pkg::DZ_W-1:0] cfg_wdata_i
);
  import gpbs_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  gpbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  gpbs_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .status_o     (dp_status),
    .in_cmd_i     (req_i.cmd),
    .in_cell_x_i  (req_i.cell_x),
    .in_cell_y_i  (req_i.cell_y),
    .in_grav_x_i  (req_i.grav_x),
    .in_grav_y_i  (req_i.grav_y),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .cell_value_o (rsp_o.cell_value)
  );

  assign rsp_o.done_res = 1'b1;

endmodule

@@ verif/gpbs_bitmap_checker.sv @@
// gpbs_bitmap_checker: watches the command, result and dead-zone ports of the particle core,
// keeps its own copy of the bitmap and dead zone, and compares every result beat in order
// depends on gpbs_pkg, gpbs_in_if and gpbs_out_if
module gpbs_bitmap_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  gpbs_in_if                        req_i,
  gpbs_out_if                       rsp_i,
  input  logic                      cfg_we_i,
  input  logic [gpbs_pkg::DZ_W-1:0] cfg_wdata_i,
  output int                        mismatch_cnt_o,
  output int                        waiting_cnt_o,
  output int                        occupied_reads_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gpbs_pkg::*;

  typedef struct packed {
    logic cell_value;
    logic done_res;
  } rsp_beat_t;

  logic [BYTE_W-1:0] bitmap_q [STORE_BYTES];
  logic [DZ_W-1:0]   dead_zone_q;
  rsp_beat_t         awaited_q [$];
  rsp_beat_t         want_beat;
  rsp_beat_t         got_beat;
  int                mismatches;
  int                occupied_reads;

  function automatic bit on_grid(int col, int row);
    return col >= 0 && col < GRID_WIDTH && row >= 0 && row < GRID_HEIGHT;
  endfunction

  function automatic bit particle_at(int col, int row);
    return bitmap_q[(row / BYTE_W) * GRID_WIDTH + col][row % BYTE_W];
  endfunction

  function automatic void set_particle(int col, int row, bit v);
    bitmap_q[(row / BYTE_W) * GRID_WIDTH + col][row % BYTE_W] = v;
  endfunction

  function automatic int axis_dir(logic signed [G_W-1:0] g);
    int dz;
    dz = int'(dead_zone_q);
    if (int'(g) < -dz) return -1;
    if (int'(g) > dz) return 1;
    return 0;
  endfunction

  // rows bottom-up, columns left to right; a particle ahead of the scan may move again
  function automatic void settle_particles(int dx, int dy);
    int tx, ty;
    for (int row = GRID_HEIGHT - 2; row > 0; row--) begin
      for (int col = 0; col < GRID_WIDTH; col++) begin
        tx = col + dx;
        ty = row + dy;
        if (particle_at(col, row) && on_grid(tx, ty) && !particle_at(tx, ty)) begin
          set_particle(tx, ty, 1'b1);
          set_particle(col, row, 1'b0);
        end
      end
    end
  endfunction

  function automatic rsp_beat_t predict_beat(cmd_e op, logic [X_W-1:0] col,
                                             logic [Y_W-1:0] row,
                                             logic signed [G_W-1:0] gx,
                                             logic signed [G_W-1:0] gy);
    rsp_beat_t r;
    r.cell_value = 1'b0;
    r.done_res   = 1'b1;
    case (op)
      CMD_SPAWN: begin
        if (on_grid(int'(col), int'(row))) set_particle(int'(col), int'(row), 1'b1);
      end
      CMD_STEP: settle_particles(axis_dir(gx), axis_dir(gy));
      CMD_READ: begin
        r.cell_value = on_grid(int'(col), int'(row)) && particle_at(int'(col), int'(row));
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (bitmap_q[i]) bitmap_q[i] = '0;
      dead_zone_q    = DEAD_ZONE_RESET;
      awaited_q.delete();
      mismatches     = 0;
      occupied_reads = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got_beat.cell_value = rsp_i.cell_value;
        got_beat.done_res   = rsp_i.done_res;
        if (awaited_q.size() == 0) begin
          flag_mismatch($sformatf("result beat with none awaited: cell_value %0b done_res %0b",
                                  got_beat.cell_value, got_beat.done_res));
        end else begin
          want_beat = awaited_q.pop_front();
          if (got_beat.cell_value !== want_beat.cell_value)
            flag_mismatch($sformatf("cell_value expected %0b actual %0b",
                                    want_beat.cell_value, got_beat.cell_value));
          if (got_beat.done_res !== want_beat.done_res)
            flag_mismatch($sformatf("done_res expected %0b actual %0b",
                                    want_beat.done_res, got_beat.done_res));
        end
      end
      if (req_i.valid && req_i.ready) begin
        want_beat = predict_beat(cmd_e'(req_i.cmd), req_i.cell_x, req_i.cell_y,
                                 req_i.grav_x, req_i.grav_y);
        awaited_q.push_back(want_beat);
        if (cmd_e'(req_i.cmd) == CMD_READ && want_beat.cell_value) occupied_reads++;
      end
      if (cfg_we_i) dead_zone_q = cfg_wdata_i;
    end
    mismatch_cnt_o   = mismatches;
    waiting_cnt_o    = awaited_q.size();
    occupied_reads_o = occupied_reads;
  end

endmodule

@@ verif/gravity_particle_bitmap_step_core_tb.sv @@
// gravity_particle_bitmap_step_core_tb: drives spawn, step, read and unused commands with
// bursty valid, a stalling ready and several dead-zone settings; gpbs_bitmap_checker judges
// depends on gpbs_pkg, gpbs_in_if, gpbs_out_if, gpbs_bitmap_checker and the core
module gravity_particle_bitmap_step_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gpbs_pkg::*;

  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 64;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [DZ_W-1:0] cfg_wdata_i;

  gpbs_in_if  req ();
  gpbs_out_if rsp ();

  int mismatches;
  int waiting;
  int occupied_reads;
  int rsp_beats;
  int burst_left;
  int n_spawn, n_step, n_read, n_nop, n_settings;
  int focus_x, focus_y;
  logic [DZ_W-1:0] dz_now;

  gravity_particle_bitmap_step_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .rsp_o       (rsp),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  gpbs_bitmap_checker bitmap_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .rsp_i            (rsp),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_cnt_o   (mismatches),
    .waiting_cnt_o    (waiting),
    .occupied_reads_o (occupied_reads)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_beats <= 0;
    end else if (rsp.valid && rsp.ready) begin
      rsp_beats <= rsp_beats + 1;
    end
  end

  // result side: own stall pattern plus two long holds to back up the core
  initial begin : result_side
    int mode, len, next_hold;
    rsp.ready = 1'b0;
    next_hold = 30;
    wait (rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len  = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        @(negedge clk_i);
        if (next_hold > 0 && rsp_beats >= next_hold) begin
          rsp.ready = 1'b0;
          repeat (LONG_HOLD) @(negedge clk_i);
          next_hold = (next_hold == 30) ? 80 : 0;
        end
        case (mode)
          0, 1:    rsp.ready = 1'b1;
          2:       rsp.ready = 1'($urandom_range(0, 1));
          default: rsp.ready = 1'b0;
        endcase
      end
    end
  end

  function automatic int fit(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  task automatic offer(input cmd_e c, input int col, input int row, input int gx,
                       input int gy);
    if (burst_left == 0) begin
      req.valid = 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5))
        @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    req.valid  = 1'b1;
    req.cmd    = c;
    req.cell_x = X_W'(col);
    req.cell_y = Y_W'(row);
    req.grav_x = G_W'(gx);
    req.grav_y = G_W'(gy);
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    @(negedge clk_i);
    burst_left--;
    case (c)
      CMD_SPAWN: n_spawn++;
      CMD_STEP:  n_step++;
      CMD_READ:  n_read++;
      default:   n_nop++;
    endcase
  endtask

  task automatic set_dead_zone(input logic [DZ_W-1:0] v);
    req.valid  = 1'b0;
    burst_left = 0;
    while (waiting != 0) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    dz_now      = v;
    n_settings++;
  endtask

  // around the dead zone edge, at the rails, tiny, or anything
  function automatic int step_gravity();
    int dz;
    dz = int'(dz_now);
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return fit(($urandom_range(0, 1) ? 1 : -1) * (dz + int'($urandom_range(0, 2)) - 1),
                    -32768, 32767);
      2: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return int'($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  task automatic random_command();
    int pick, col, row, gx, gy;
    cmd_e c;
    pick = $urandom_range(0, 99);
    c = (pick < 8) ? CMD_STEP : (pick < 13) ? CMD_NOP : (pick < 58) ? CMD_SPAWN : CMD_READ;
    if ($urandom_range(0, 14) == 0) begin
      focus_x = $urandom_range(0, GRID_WIDTH - 1);
      focus_y = $urandom_range(0, GRID_HEIGHT - 1);
    end
    case ($urandom_range(0, 4))
      0, 1, 2: begin
        col = fit(focus_x + int'($urandom_range(0, 6)) - 3, 0, GRID_WIDTH - 1);
        row = fit(focus_y + int'($urandom_range(0, 6)) - 3, 0, GRID_HEIGHT - 1);
      end
      3: begin
        col = $urandom_range(0, GRID_WIDTH - 1);
        row = $urandom_range(0, GRID_HEIGHT - 1);
        if ($urandom_range(0, 1)) col = $urandom_range(0, 1) ? GRID_WIDTH - 1 : 0;
        else row = $urandom_range(0, 1) ? GRID_HEIGHT - 1 : 0;
      end
      default: begin
        col = $urandom_range(0, GRID_WIDTH - 1);
        row = $urandom_range(0, GRID_HEIGHT - 1);
      end
    endcase
    gx = int'($urandom_range(0, 65535)) - 32768;
    gy = int'($urandom_range(0, 65535)) - 32768;
    if (c == CMD_STEP) begin
      gx = step_gravity();
      gy = step_gravity();
    end
    offer(c, col, row, gx, gy);
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    req.valid   = 1'b0;
    req.cmd     = CMD_SPAWN;
    req.cell_x  = '0;
    req.cell_y  = '0;
    req.grav_x  = '0;
    req.grav_y  = '0;
    burst_left  = 0;
    n_spawn     = 0;
    n_step      = 0;
    n_read      = 0;
    n_nop       = 0;
    n_settings  = 1;
    dz_now      = DEAD_ZONE_RESET;
    focus_x     = $urandom_range(0, GRID_WIDTH - 1);
    focus_y     = $urandom_range(0, GRID_HEIGHT - 1);
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset dead zone
    offer(CMD_READ, 0, 0, 0, 0);
    offer(CMD_SPAWN, 0, 0, 0, 0);
    offer(CMD_SPAWN, 127, 0, 0, 0);
    offer(CMD_SPAWN, 0, 63, 0, 0);
    offer(CMD_SPAWN, 127, 63, 0, 0);
    offer(CMD_SPAWN, 127, 62, 0, 0);
    offer(CMD_SPAWN, 0, 1, 0, 0);
    offer(CMD_SPAWN, 64, 62, 0, 0);
    offer(CMD_SPAWN, 64, 61, 0, 0);
    offer(CMD_SPAWN, 64, 30, 0, 0);
    offer(CMD_SPAWN, 5, 8, 0, 0);
    offer(CMD_SPAWN, 5, 7, 0, 0);
    offer(CMD_READ, 127, 63, 0, 0);
    offer(CMD_STEP, 0, 0, 2, -2);
    offer(CMD_STEP, 0, 0, 0, 3);
    offer(CMD_NOP, 127, 63, -32768, 32767);
    offer(CMD_STEP, 0, 0, -32768, -32768);
    offer(CMD_READ, 0, 0, 0, 0);
    offer(CMD_READ, 64, 63, 0, 0);
    offer(CMD_STEP, 0, 0, 32767, 0);
    offer(CMD_READ, 127, 1, 0, 0);
    offer(CMD_READ, 127, 63, 0, 0);
    offer(CMD_READ, 5, 9, 0, 0);

    set_dead_zone('0);
    repeat (25) random_command();
    set_dead_zone('1);
    repeat (25) random_command();
    set_dead_zone(DZ_W'($urandom_range(1, 300)));
    repeat (25) random_command();
    set_dead_zone(DEAD_ZONE_RESET);
    repeat (25) random_command();

    req.valid = 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d commands (%0d spawn, %0d step, %0d read, %0d unused) over %0d dead zones",
             n_spawn + n_step + n_read + n_nop, n_spawn, n_step, n_read, n_nop, n_settings);
    $display("%0d reads found a particle, %0d result beats, %0d mismatches",
             occupied_reads, rsp_beats, mismatches);
    if (mismatches == 0 && waiting == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
